/* design/dwsm_pkg.sv */
`timescale 1ns / 1ps

package dwsm_pkg;

   localparam int DWSM_QUEUE_DEPTH = 2;

   // Usual number of sources per mix point; the count register saturates well above it.
   localparam int MAX_SOURCES = 8;

   localparam logic [15:0] GAIN_RESET = 16'd18022;
   localparam logic [15:0] FULL_SCALE = 16'd40960;
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;
   localparam logic [21:0] SUM_MAX    = 22'h3F_FFFF;
   localparam logic [6:0]  COUNT_MAX  = 7'd127;

   // Iteration counts of the root unit and of the shared divide unit.
   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS  = 34;
   localparam int STEP_W     = 6;

   // One accepted beat after the front end has classified it.
   typedef struct packed {
      logic signed [16:0] sample_level;
      logic [15:0]        source_x;
      logic [15:0]        source_y;
      logic [15:0]        source_radius;
      logic [15:0]        mix_x;
      logic [15:0]        mix_y;
      logic               source_connected;
      logic               last_source;
      logic               reject;
   } item_type;

   // Handshake between the front queue and the back end.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

/* design/dwsm_front.sv */
`timescale 1ns / 1ps

module dwsm_front #(
   parameter int QUEUE_DEPTH = dwsm_pkg::DWSM_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [103:0]            req_tdata,
   input  logic                    req_tuser,
   input  logic                    req_tlast,
   output dwsm_pkg::queue_out_type q_out,
   input  logic                    q_pop
);
   import dwsm_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   item_type            new_item;
   logic                push;
   logic                pop;

   // Classify on the way in: an unpatched source or a zero radius can never be in range.
   always_comb begin
      new_item.sample_level     = $signed(req_tdata[16:0]);
      new_item.source_x         = req_tdata[32:17];
      new_item.source_y         = req_tdata[48:33];
      new_item.source_radius    = req_tdata[64:49];
      new_item.mix_x            = req_tdata[80:65];
      new_item.mix_y            = req_tdata[96:81];
      new_item.source_connected = req_tuser;
      new_item.last_source      = req_tlast;
      new_item.reject           = !req_tuser || (req_tdata[64:49] == 16'd0);
   end

   assign req_tready  = (count_ff != FullCnt);
   assign push        = req_tvalid && req_tready;
   assign pop         = q_pop && (count_ff != '0);
   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* design/dwsm_back.sv */
`timescale 1ns / 1ps

module dwsm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  dwsm_pkg::queue_out_type q_out,
   output logic                    q_pop,
   input  logic [15:0]             weight_gain,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);
   import dwsm_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SQUARE  = 4'd1;
   localparam logic [3:0] ST_COMPARE = 4'd2;
   localparam logic [3:0] ST_SQRT    = 4'd3;
   localparam logic [3:0] ST_WMUL    = 4'd4;
   localparam logic [3:0] ST_DIV     = 4'd5;
   localparam logic [3:0] ST_SMUL    = 4'd6;
   localparam logic [3:0] ST_ACC     = 4'd7;
   localparam logic [3:0] ST_OUT     = 4'd8;

   logic [3:0]        state_ff;
   item_type          item_ff;
   logic [31:0]       px_ff, py_ff, rr_ff;
   logic              hit_ff;
   logic [31:0]       rem_ff, root_ff, bit_ff;
   logic [STEP_W-1:0] step_ff;
   logic [33:0]       dvd_ff;
   logic [15:0]       drem_ff, divisor_ff;
   logic              div_mean_ff;
   logic [16:0]       weight_ff;
   logic [15:0]       contrib_ff, level_ff;
   logic [21:0]       sum_ff;
   logic [6:0]        count_ff;
   logic              out_valid_ff;
   logic [15:0]       out_contrib_ff, out_level_ff;
   logic              out_hit_ff, out_last_ff;

   logic [15:0] dx, dy;
   logic [32:0] d2;
   logic [32:0] root_try;
   logic [16:0] drem_sh;
   logic        dbit;
   logic [15:0] sample_clamped;
   logic [32:0] sample_prod;
   logic [22:0] sum_wide;
   logic [21:0] sum_in;
   logic [6:0]  count_in;
   logic        out_free;

   assign dx = (item_ff.source_x > item_ff.mix_x) ? item_ff.source_x - item_ff.mix_x
                                                   : item_ff.mix_x - item_ff.source_x;
   assign dy = (item_ff.source_y > item_ff.mix_y) ? item_ff.source_y - item_ff.mix_y
                                                   : item_ff.mix_y - item_ff.source_y;
   assign d2       = {1'b0, px_ff} + {1'b0, py_ff};
   assign root_try = {1'b0, root_ff} + {1'b0, bit_ff};
   assign drem_sh  = {drem_ff, dvd_ff[33]};
   assign dbit     = (drem_sh >= {1'b0, divisor_ff});

   always_comb begin
      if (item_ff.sample_level[16]) begin
         sample_clamped = '0;
      end else if (item_ff.sample_level[15:0] > FULL_SCALE) begin
         sample_clamped = FULL_SCALE;
      end else begin
         sample_clamped = item_ff.sample_level[15:0];
      end
   end

   assign sample_prod = 33'(sample_clamped * weight_ff);
   assign sum_wide    = {1'b0, sum_ff} + {7'd0, contrib_ff};
   assign sum_in      = !hit_ff ? sum_ff : (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX
                                                                         : sum_wide[21:0];
   assign count_in    = (hit_ff && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign out_free    = !out_valid_ff || rsp_tready;
   assign q_pop       = (state_ff == ST_IDLE) && q_out.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_out.valid) begin
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE:  state_ff <= ST_COMPARE;
            ST_COMPARE: state_ff <= (!item_ff.reject && d2 < {1'b0, rr_ff}) ? ST_SQRT : ST_ACC;
            ST_SQRT: begin
               if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
                  state_ff <= ST_WMUL;
               end
            end
            ST_WMUL: state_ff <= ST_DIV;
            ST_DIV: begin
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= div_mean_ff ? ST_OUT : ST_SMUL;
               end
            end
            ST_SMUL: state_ff <= ST_ACC;
            ST_ACC: begin
               if (item_ff.last_source) begin
                  sum_ff   <= '0;
                  count_ff <= '0;
                  state_ff <= (count_in != '0) ? ST_DIV : ST_OUT;
               end else begin
                  sum_ff   <= sum_in;
                  count_ff <= count_in;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_ff <= q_out.item;
         end
         ST_SQUARE: begin
            px_ff <= 32'(dx * dx);
            py_ff <= 32'(dy * dy);
            rr_ff <= 32'(item_ff.source_radius * item_ff.source_radius);
         end
         ST_COMPARE: begin
            hit_ff     <= !item_ff.reject && d2 < {1'b0, rr_ff};
            contrib_ff <= '0;
            level_ff   <= '0;
            rem_ff     <= d2[31:0];
            root_ff    <= '0;
            bit_ff     <= 32'h4000_0000;
            step_ff    <= '0;
         end
         ST_SQRT: begin
            if ({1'b0, rem_ff} >= root_try) begin
               rem_ff  <= rem_ff - root_try[31:0];
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 1'b1;
         end
         ST_WMUL: begin
            dvd_ff      <= {32'(weight_gain * (item_ff.source_radius - root_ff[15:0])), 2'b00};
            divisor_ff  <= item_ff.source_radius;
            drem_ff     <= '0;
            div_mean_ff <= 1'b0;
            step_ff     <= '0;
         end
         ST_DIV: begin
            drem_ff <= dbit ? 16'(drem_sh - {1'b0, divisor_ff}) : drem_sh[15:0];
            dvd_ff  <= {dvd_ff[32:0], dbit};
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               if (div_mean_ff) begin
                  level_ff <= ({dvd_ff[32:0], dbit} > {18'd0, FULL_SCALE}) ? FULL_SCALE
                              : {dvd_ff[14:0], dbit};
               end else begin
                  weight_ff <= ({dvd_ff[32:0], dbit} > {17'd0, WEIGHT_ONE}) ? WEIGHT_ONE
                               : {dvd_ff[15:0], dbit};
               end
            end
         end
         ST_SMUL: begin
            contrib_ff <= sample_prod[31:16];
         end
         ST_ACC: begin
            dvd_ff      <= {12'd0, sum_in};
            divisor_ff  <= {9'd0, count_in};
            drem_ff     <= '0;
            div_mean_ff <= 1'b1;
            step_ff     <= '0;
         end
         ST_OUT: begin
            if (out_free) begin
               out_contrib_ff <= contrib_ff;
               out_level_ff   <= level_ff;
               out_hit_ff     <= hit_ff;
               out_last_ff    <= item_ff.last_source;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_level_ff, out_contrib_ff};
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

/* design/distance_weighted_spatial_mixer_core.sv */
`timescale 1ns / 1ps

// Distance-weighted spatial mixer. Each request beat pairs one source with one mix point;
// the block finds their Euclidean distance and, for a patched source closer than its
// radius, weights the sample (clamped to 0..10 V at 4096 codes per volt) by
// min(1, weight_gain * (r - d) / r). Every request beat gives exactly one response beat
// holding that source's contribution and an in-range flag; the beat that carries
// tlast also carries the average of the in-range contributions of its mix point (0 if
// none was in range), after which the running sum and count start over. A front queue
// takes beats while the back end works, and a response register lets the back end
// finish its next beat while the previous one waits. Throughput is set by the back end,
// which handles one beat at a time: square, compare, accumulate and output for a source
// out of range, plus square root, weight multiply, the shared restoring divider and
// sample multiply in range, and a second divide on tlast if any source was in range.
module distance_weighted_spatial_mixer_core #(
   parameter int QUEUE_DEPTH = dwsm_pkg::DWSM_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // sample_level[16:0], source_x[32:17], source_y[48:33], source_radius[64:49],
   // mix_x[80:65], mix_y[96:81], zero fill [103:97]
   input  logic [103:0] req_tdata,
   // source_connected
   input  logic         req_tuser,
   // last_source
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // contribution[15:0], mix_level[31:16]
   output logic [31:0]  rsp_tdata,
   // in_range
   output logic         rsp_tuser,
   // mix_valid
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   import dwsm_pkg::*;

   logic [15:0]   weight_gain_ff;
   queue_out_type q_out;
   logic          q_pop;

   // The user is to write the gain register only while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         weight_gain_ff <= csr_wr_data;
      end
   end

   dwsm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   dwsm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .weight_gain(weight_gain_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/dwsm_checker.sv */
`timescale 1ns / 1ps

module dwsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // A stalled response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // A source out of range contributes nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == 16'd0)
      else $error("contribution from a source out of range");

   // The mix level is only reported on the last source of a mix point.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[31:16] == 16'd0)
      else $error("mix level outside the last beat");

   // Both levels stay within full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= 16'd40960 && rsp_tdata[31:16] <= 16'd40960)
      else $error("level above full scale");

   // No response is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind distance_weighted_spatial_mixer_core dwsm_checker u_dwsm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .rsp_tlast (rsp_tlast)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps

// Checks the spatial mixer core against a predictor of its fixed-point arithmetic.
// A directed table comes first, then random groups of sources for each mix point.
// Both stream sides idle and stall at random; the gain register changes between phases.
module testbench;
   import dwsm_pkg::*;

   typedef struct packed {
      logic signed [16:0] sample_level;
      logic               source_connected;
      logic [15:0]        source_x;
      logic [15:0]        source_y;
      logic [15:0]        source_radius;
      logic [15:0]        mix_x;
      logic [15:0]        mix_y;
      logic               last_source;
   } source_beat_type;

   typedef struct packed {
      logic [15:0] contribution;
      logic        in_range;
      logic [15:0] mix_level;
      logic        mix_valid;
   } mix_result_type;

   // One row of the directed table. When has_fixed is set, the row carries a
   // typed-in result and the predictor must agree with it.
   typedef struct packed {
      source_beat_type beat;
      logic            has_fixed;
      mix_result_type  fixed;
   } table_row_type;

   localparam int  LIMIT_CYCLES = 400000;
   localparam int  TAIL_CYCLES  = 200;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [103:0] req_tdata;
   logic         req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en;
   logic [15:0]  csr_wr_data;

   distance_weighted_spatial_mixer_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Predictor state: mirrors the gain register and the running sum and count.
   logic [15:0] gain_q;
   logic [21:0] sum_q;
   logic [6:0]  count_q;

   mix_result_type expected_mixes[$];
   int          error_count;
   int          beats_sent;
   int          mixes_seen;
   int          hits_seen;
   int          cycle_count;
   bit          calm;   // set while neither side idles

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   function automatic logic [31:0] root_floor(input logic [31:0] v);
      logic [31:0] rem;
      logic [31:0] res;
      logic [31:0] bitv;
      rem  = v;
      res  = 0;
      bitv = 32'h4000_0000;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Weighs one source, updates the running sums and returns the expected beat.
   function automatic mix_result_type predict_mix(input source_beat_type b);
      mix_result_type r;
      logic [16:0] dx, dy;
      logic [33:0] d2;
      logic [31:0] d;
      logic [63:0] w;
      logic [16:0] s;
      logic [63:0] c;
      logic [22:0] acc;
      logic [21:0] lvl;
      logic        hit;
      dx  = b.source_x > b.mix_x ? b.source_x - b.mix_x : b.mix_x - b.source_x;
      dy  = b.source_y > b.mix_y ? b.source_y - b.mix_y : b.mix_y - b.source_y;
      d2  = dx * dx + dy * dy;
      hit = b.source_connected && b.source_radius != 0 &&
            d2 < 34'(b.source_radius) * b.source_radius;
      r = '0;
      if (hit) begin
         d = root_floor(d2[31:0]);
         w = (64'(gain_q) * (b.source_radius - d) * 4) / b.source_radius;
         if (w > 65536) w = 65536;
         if (b.sample_level < 0) s = 0;
         else if (b.sample_level > 40960) s = 40960;
         else s = b.sample_level;
         c = (64'(s) * w) >> 16;
         r.contribution = c[15:0];
         acc   = sum_q + c[15:0];
         sum_q = acc > SUM_MAX ? SUM_MAX : acc[21:0];
         if (count_q < COUNT_MAX) count_q++;
      end
      r.in_range = hit;
      if (b.last_source) begin
         if (count_q != 0) begin
            lvl = sum_q / count_q;
            r.mix_level = lvl > FULL_SCALE ? FULL_SCALE : lvl[15:0];
         end
         sum_q   = 0;
         count_q = 0;
      end
      r.mix_valid = b.last_source;
      return r;
   endfunction

   // Drives one beat from a falling edge and holds it until it is taken.
   // The valid line drops only while the source idles or the stimulus pauses.
   task automatic send_source(input source_beat_type b);
      while (!calm && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, b.mix_y, b.mix_x, b.source_radius, b.source_y, b.source_x,
                     b.sample_level};
      req_tuser  <= b.source_connected;
      req_tlast  <= b.last_source;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_mixes.push_back(predict_mix(b));
      beats_sent++;
      @(negedge clock);
   endtask

   // The gain is written only with nothing in flight.
   task automatic write_gain(input logic [15:0] g);
      req_tvalid <= 1'b0;
      while (expected_mixes.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      gain_q = g;
   endtask

   function automatic source_beat_type random_source(input bit near, input bit last);
      source_beat_type b;
      b.sample_level     = $urandom_range(7) == 0 ? 17'($urandom) : 17'($urandom_range(40960));
      b.source_connected = $urandom_range(9) != 0;
      b.mix_x            = $urandom;
      b.mix_y            = $urandom;
      if (near) begin
         b.source_x      = b.mix_x + 16'($urandom_range(8000)) - 16'd4000;
         b.source_y      = b.mix_y + 16'($urandom_range(8000)) - 16'd4000;
         b.source_radius = $urandom_range(65535, 1);
      end else begin
         b.source_x      = $urandom;
         b.source_y      = $urandom;
         b.source_radius = $urandom;
      end
      b.last_source = last;
      return b;
   endfunction

   // Response side: stalls at random, checks each beat at the rising edge.
   always @(negedge clock)
      rsp_tready <= calm || reset || $urandom_range(99) >= 8;

   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_mixes.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[15:0], 0);
         end else begin
            want = expected_mixes.pop_front();
            if (rsp_tdata[15:0] !== want.contribution)
               report_mismatch("contribution", rsp_tdata[15:0], want.contribution);
            if (rsp_tuser !== want.in_range)
               report_mismatch("in_range", rsp_tuser, want.in_range);
            if (rsp_tdata[31:16] !== want.mix_level)
               report_mismatch("mix_level", rsp_tdata[31:16], want.mix_level);
            if (rsp_tlast !== want.mix_valid)
               report_mismatch("mix_valid", rsp_tlast, want.mix_valid);
            hits_seen  += want.in_range;
            mixes_seen += want.mix_valid;
         end
      end
   end

   table_row_type   directed[$];
   source_beat_type b;
   mix_result_type  got;
   int              group;

   initial begin
      clock = 0; reset = 1; calm = 0;
      req_tvalid = 0; req_tdata = '0; req_tuser = 0; req_tlast = 0;
      rsp_tready = 0; csr_wr_en = 0; csr_wr_data = '0;
      error_count = 0; beats_sent = 0; mixes_seen = 0; hits_seen = 0; cycle_count = 0;
      gain_q = GAIN_RESET; sum_q = 0; count_q = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed rows: sample, conn, sx, sy, r, mx, my, last.
      // A lone in-range source at distance zero with the default gain of 1.1
      // saturates its weight, so its contribution equals the clamped sample.
      directed.push_back('{'{17'sd40960, 1, 16'd100, 16'd100, 16'hFFFF, 16'd100, 16'd100, 1},
                           1, '{16'd40960, 1, 16'd40960, 1}});
      // Sample above full scale is clamped.
      directed.push_back('{'{17'sd65535, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1},
                           1, '{16'd40960, 1, 16'd40960, 1}});
      // Negative sample clamps to zero.
      directed.push_back('{'{-17'sd65536, 1, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 1},
                           1, '{16'd0, 1, 16'd0, 1}});
      // Zero radius never reaches; last with nothing in range gives zero.
      directed.push_back('{'{17'sd20000, 1, 16'd5, 16'd5, 16'd0, 16'd5, 16'd5, 1},
                           1, '{16'd0, 0, 16'd0, 1}});
      // Unplugged source is ignored.
      directed.push_back('{'{17'sd20000, 0, 16'd5, 16'd5, 16'd900, 16'd5, 16'd5, 1},
                           1, '{16'd0, 0, 16'd0, 1}});
      // Opposite corners, full radius: out of range.
      directed.push_back('{'{17'sd4096, 1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1},
                           1, '{16'd0, 0, 16'd0, 1}});
      // Distance exactly equal to radius is out of range.
      directed.push_back('{'{17'sd4096, 1, 16'd0, 16'd0, 16'd300, 16'd300, 16'd0, 1},
                           1, '{16'd0, 0, 16'd0, 1}});
      // A group of partial weights, a lone source, then a mixed group.
      directed.push_back('{'{17'sd30000, 1, 16'd0, 16'd0, 16'd1000, 16'd500, 16'd400, 0}, 0, '0});
      directed.push_back('{'{17'sd10000, 1, 16'd800, 16'd0, 16'd1000, 16'd500, 16'd400, 0}, 0, '0});
      directed.push_back('{'{17'sd40000, 1, 16'd505, 16'd399, 16'd7, 16'd500, 16'd400, 0}, 0, '0});
      directed.push_back('{'{17'sd12345, 1, 16'd501, 16'd401, 16'd2, 16'd500, 16'd400, 1}, 0, '0});
      directed.push_back('{'{17'sd1, 1, 16'hFFFF, 16'h0, 16'd1, 16'hFFFF, 16'h0, 1}, 0, '0});
      directed.push_back('{'{17'sd40960, 1, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 0}, 0, '0});
      directed.push_back('{'{17'sd40960, 1, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0, 16'h0, 1}, 0, '0});

      foreach (directed[i]) begin
         if (directed[i].has_fixed) begin
            // The typed-in result must agree with the predictor from a cleared running sum and count.
            got = predict_mix(directed[i].beat);
            if (got !== directed[i].fixed)
               report_mismatch("directed row", i, 0);
            gain_q = gain_q; sum_q = 0; count_q = 0;
         end
      end
      sum_q = 0; count_q = 0;
      foreach (directed[i]) send_source(directed[i].beat);

      // Random phases through several gain settings, extremes included.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_gain(16'd0);
            1: write_gain(16'hFFFF);
            2: write_gain(16'($urandom_range(20000, 8000)));
            3: write_gain(16'd16384);
            default: write_gain(GAIN_RESET);
         endcase
         calm = (phase == 2);
         for (group = 0; group < 30; group++) begin
            int n;
            n = $urandom_range(MAX_SOURCES, 1);
            for (int k = 0; k < n; k++)
               send_source(random_source($urandom_range(3) != 0, k == n - 1));
         end
      end
      calm = 0;
      // A long run without a last mark drives the count into saturation.
      for (int k = 0; k < 140; k++) begin
         b = random_source(1, k == 139);
         b.source_connected = 1;
         b.sample_level = 40960;
         b.source_x = b.mix_x; b.source_y = b.mix_y; b.source_radius = 16'hFFFF;
         send_source(b);
      end
      req_tvalid <= 1'b0;

      while (expected_mixes.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("sent %0d source beats, %0d in range, %0d mix results checked",
               beats_sent, hits_seen, mixes_seen);
      $display("gain settings: reset, zero, full, random, unity, reset; %0d mismatches",
               error_count);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
